// ===== sv/ptt_pkg.sv =====
package ptt_pkg;

    // Accumulator width default for summed DMP overflow samples
    localparam int ACCUM_WIDTH_DEF = 40;

    // Machine clock field width and divider/addend width
    localparam int MCLK_W = 21;
    localparam int DIV_W  = 32;

    // Configuration register indexes
    localparam logic [2:0] CFG_TAPE_FORMAT    = 3'd0;
    localparam logic [2:0] CFG_TAP_VERSION    = 3'd1;
    localparam logic [2:0] CFG_MACHINE_TYPE   = 3'd2;
    localparam logic [2:0] CFG_VIDEO_STANDARD = 3'd3;
    localparam logic [2:0] CFG_COUNTER_RATE   = 3'd4;

    // Source formats
    localparam logic [1:0] FMT_TAP  = 2'd0;
    localparam logic [1:0] FMT_DMP  = 2'd1;
    localparam logic [1:0] FMT_HTAP = 2'd2;
    localparam logic [1:0] FMT_NONE = 2'd3;

    localparam logic [1:0] VER_SHORT    = 2'd0;
    localparam logic [1:0] VER_V1       = 2'd1;
    localparam logic [1:0] VER_HALFWAVE = 2'd2;

    localparam logic [1:0] MACH_DEFAULT = 2'd0;
    localparam logic [1:0] MACH_ALT1    = 2'd1;
    localparam logic [1:0] MACH_ALT2    = 2'd2;

    // Clock and timing constants
    localparam logic [MCLK_W-1:0] CLK_NTSC      = 21'd1022727;
    localparam logic [MCLK_W-1:0] CLK_ALT1_PAL  = 21'd1108405;
    localparam logic [MCLK_W-1:0] CLK_ALT2_NTSC = 21'd894886;
    localparam logic [MCLK_W-1:0] CLK_ALT2_PAL  = 21'd886724;
    localparam logic [MCLK_W-1:0] CLK_PAL       = 21'd985248;
    localparam logic [31:0] SHORT_PAUSE   = 32'd20000;
    localparam logic [31:0] RATE_DEFAULT  = 32'd2000000;
    localparam logic [31:0] HALF_USEC_ADD = 32'd1000000;
    localparam logic [15:0] OVF_SAMPLE    = 16'hFFFF;
    localparam logic [14:0] PAUSE_MASK    = 15'h7FFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_SCALE,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_ADD,
        SC_DIV
    } scl_state_t;

    // Machine clock selection
    function automatic logic [MCLK_W-1:0] clock_hz(input logic [1:0] mtype,
                                                   input logic ntsc);
        logic [MCLK_W-1:0] c;
        case (mtype)
            MACH_ALT1: c = ntsc ? CLK_NTSC : CLK_ALT1_PAL;
            MACH_ALT2: c = ntsc ? CLK_ALT2_NTSC : CLK_ALT2_PAL;
            default:   c = ntsc ? CLK_NTSC : CLK_PAL;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/ptt_scale_unit.sv =====
// Serial (operand * mclk + addend) / divisor, quotient mod 2^32
module ptt_scale_unit #(
    parameter int OP_WIDTH = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [OP_WIDTH-1:0]         operand,
    input  logic [ptt_pkg::MCLK_W-1:0]  mclk,
    input  logic [ptt_pkg::DIV_W-1:0]   divisor,
    input  logic [ptt_pkg::DIV_W-1:0]   addend,
    output logic                        busy,
    output logic                        done,
    output logic [ptt_pkg::DIV_W-1:0]   quotient
);
    import ptt_pkg::*;

    localparam int PW = OP_WIDTH + MCLK_W + 1;
    localparam int CW = $clog2(PW);

    scl_state_t state_reg, state_next;
    logic [OP_WIDTH-1:0] op_reg;
    logic [MCLK_W-1:0]   mul_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [DIV_W-1:0]    add_reg;
    logic [PW-1:0]       acc_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [CW-1:0]       cnt_reg;
    logic [DIV_W:0]      rem_shift;
    logic                rem_ge;

    assign rem_shift = {rem_reg, acc_reg[PW-1]};
    assign rem_ge    = rem_shift >= {1'b0, div_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SC_IDLE: if (start) state_next = SC_MUL;
            SC_MUL:  if (cnt_reg == '0) state_next = SC_ADD;
            SC_ADD:  state_next = SC_DIV;
            SC_DIV:  if (cnt_reg == '0) state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy = state_reg != SC_IDLE;
        done = state_reg == SC_DIV && cnt_reg == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SC_IDLE;
        else
            state_reg <= state_next;
    end

    // Shift-add multiply, one addend step, restoring divide
    always_ff @(posedge clk)
    begin
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    op_reg  <= operand;
                    mul_reg <= mclk;
                    div_reg <= divisor;
                    add_reg <= addend;
                    acc_reg <= '0;
                    cnt_reg <= CW'(MCLK_W - 1);
                end
            end
            SC_MUL:
            begin
                acc_reg <= {acc_reg[PW-2:0], 1'b0}
                         + (mul_reg[MCLK_W-1] ? PW'(op_reg) : '0);
                mul_reg <= {mul_reg[MCLK_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            SC_ADD:
            begin
                acc_reg <= acc_reg + PW'(add_reg);
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CW'(PW - 1);
            end
            SC_DIV:
            begin
                rem_reg <= rem_ge ? DIV_W'(rem_shift - {1'b0, div_reg})
                                  : rem_shift[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
                acc_reg <= {acc_reg[PW-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    assign quotient = quo_reg;

endmodule

// ===== sv/tape_pulse_to_tap_v1_converter_top.sv =====
// Flow: an accepted byte passes the gather and finish states before its results
// are offered in the emit state; a DMP or HTAP record that needs scaling also
// waits in the scale state on the shared serial multiply/divide unit.
// Throughput: one byte at a time, with up to 4 results per byte; the next
// byte can be taken the cycle after the last result is delivered.
// Reset: asynchronous active-low; configuration returns to its defaults.
module tape_pulse_to_tap_v1_converter_top #(
    parameter int ACCUM_WIDTH = ptt_pkg::ACCUM_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  ptt_pkg::in_t  in_data,
    input  logic         in_valid,
    output logic         in_ready,
    output ptt_pkg::out_t out_data,
    output logic         out_valid,
    input  logic         out_ready,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import ptt_pkg::*;

    localparam int OW  = (ACCUM_WIDTH > 33) ? ACCUM_WIDTH : 33;
    localparam int AW1 = ACCUM_WIDTH + 1;

    // Configuration
    logic [1:0]  fmt_reg, ver_reg, mtype_reg;
    logic        vstd_reg;
    logic [31:0] rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_TAP;
            ver_reg   <= VER_V1;
            mtype_reg <= MACH_DEFAULT;
            vstd_reg  <= 1'b0;
            rate_reg  <= RATE_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAPE_FORMAT:    fmt_reg   <= cfg_data[1:0];
                CFG_TAP_VERSION:    ver_reg   <= cfg_data[1:0];
                CFG_MACHINE_TYPE:   mtype_reg <= cfg_data[1:0];
                CFG_VIDEO_STANDARD: vstd_reg  <= cfg_data[0];
                CFG_COUNTER_RATE:   rate_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;

    logic [7:0]             byte_reg;
    logic                   last_reg;
    logic [63:0]            rb_reg;
    logic [3:0]             pos_reg;
    logic [ACCUM_WIDTH-1:0] ovf_reg;
    logic [31:0]            hsum_reg;
    logic                   pend_reg;
    logic [31:0]            cyc_reg;
    logic                   got_reg;
    logic                   useq_reg;
    logic [7:0]             obuf_reg [4];
    logic [2:0]             ocnt_reg;
    logic [1:0]             oidx_reg;
    logic                   mark_reg;

    // Shared unit
    logic              scl_start, scl_busy, scl_done;
    logic [OW-1:0]     scl_op;
    logic [31:0]       scl_div, scl_add, scl_quo;
    logic [MCLK_W-1:0] mclk;

    assign mclk = clock_hz(mtype_reg, vstd_reg);

    ptt_scale_unit #(.OP_WIDTH(OW)) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scl_start),
        .operand  (scl_op),
        .mclk     (mclk),
        .divisor  (scl_div),
        .addend   (scl_add),
        .busy     (scl_busy),
        .done     (scl_done),
        .quotient (scl_quo)
    );

    // Record gathering and decode
    logic                   halfwaves, active, complete, need_scale, got_now;
    logic [63:0]            rb_new;
    logic [3:0]             pos_new, need;
    logic [15:0]            word;
    logic [ACCUM_WIDTH:0]   dsum;
    logic [ACCUM_WIDTH-1:0] tsat;
    logic [32:0]            ticks;
    logic [31:0]            rate_eff, cyc_now;

    assign halfwaves = fmt_reg == FMT_HTAP || (fmt_reg == FMT_TAP && ver_reg == VER_HALFWAVE);
    assign active    = fmt_reg != FMT_NONE && !pos_reg[3];
    assign rb_new    = rb_reg | (64'(byte_reg) << {pos_reg[2:0], 3'b000});
    assign pos_new   = pos_reg + 4'd1;
    assign word      = rb_new[15:0];
    assign dsum      = {1'b0, ovf_reg} + AW1'(word);
    assign tsat      = dsum[ACCUM_WIDTH] ? '1 : dsum[ACCUM_WIDTH-1:0];
    assign rate_eff  = (rate_reg == '0) ? RATE_DEFAULT : rate_reg;

    always_comb
    begin
        case (fmt_reg)
            FMT_TAP:  need = (word[7:0] != 8'd0 || ver_reg == VER_SHORT) ? 4'd1 : 4'd4;
            FMT_DMP:  need = 4'd2;
            default:  need = (pos_new < 4'd2) ? 4'd2
                           : ((word[14:0] & PAUSE_MASK) == '0) ? 4'd8 : 4'd2;
        endcase
    end

    assign complete = active && pos_new >= need;

    always_comb
    begin
        need_scale = 1'b0;
        got_now    = 1'b0;
        cyc_now    = '0;
        scl_op     = '0;
        scl_div    = rate_eff;
        scl_add    = {1'b0, rate_eff[31:1]};
        if ((word[14:0] & PAUSE_MASK) == '0)
            ticks = {rb_new[47:32], rb_new[63:48], 1'b0};
        else
            ticks = {18'd0, word[14:0]};
        if (complete)
        begin
            case (fmt_reg)
                FMT_TAP:
                begin
                    got_now = 1'b1;
                    if (word[7:0] != 8'd0)
                        cyc_now = {21'd0, word[7:0], 3'b000};
                    else if (ver_reg == VER_SHORT)
                        cyc_now = SHORT_PAUSE;
                    else
                        cyc_now = {8'd0, rb_new[31:8]};
                end
                FMT_DMP:
                begin
                    need_scale = word != OVF_SAMPLE;
                    scl_op     = OW'(tsat);
                end
                default:
                begin
                    need_scale = 1'b1;
                    scl_op     = OW'(ticks);
                    scl_div    = RATE_DEFAULT;
                    scl_add    = HALF_USEC_ADD;
                end
            endcase
        end
    end

    // Finish: halfwave pairing and byte coding
    logic        f_emit, f_hp;
    logic [31:0] f_cyc, f_d, f_hs, f_round;
    logic        f_short;

    always_comb
    begin
        f_cyc  = useq_reg ? scl_quo : cyc_reg;
        f_hp   = pend_reg;
        f_hs   = hsum_reg;
        f_emit = 1'b0;
        f_d    = '0;
        if (got_reg)
        begin
            if (f_hp)
            begin
                f_emit = 1'b1;
                f_d    = f_hs + f_cyc;
                f_hp   = 1'b0;
                f_hs   = '0;
            end
            else if (halfwaves)
            begin
                f_hs = f_cyc;
                f_hp = 1'b1;
            end
            else
            begin
                f_emit = 1'b1;
                f_d    = f_cyc;
            end
        end
        if (last_reg)
        begin
            if (f_hp)
            begin
                f_emit = 1'b1;
                f_d    = f_hs;
            end
            f_hp = 1'b0;
            f_hs = '0;
        end
        f_short = f_d >= 32'd8 && f_d <= 32'd2040;
        f_round = f_d + 32'd4;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_GATHER;
            ST_GATHER: state_next = need_scale ? ST_SCALE : ST_FINISH;
            ST_SCALE:  if (scl_done) state_next = ST_FINISH;
            ST_FINISH: state_next = (f_emit || last_reg) ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (out_ready && {1'b0, oidx_reg} == ocnt_reg - 3'd1)
                           state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready  = state_reg == ST_IDLE;
        out_valid = state_reg == ST_EMIT;
        scl_start = state_reg == ST_GATHER && need_scale;
    end

    assign out_data.out_byte  = mark_reg ? 8'd0 : obuf_reg[oidx_reg];
    assign out_data.out_valid = !mark_reg;
    assign out_data.out_last  = last_reg && {1'b0, oidx_reg} == ocnt_reg - 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rb_reg    <= '0;
            pos_reg   <= '0;
            ovf_reg   <= '0;
            hsum_reg  <= '0;
            pend_reg  <= 1'b0;
            oidx_reg  <= '0;
            ocnt_reg  <= '0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_GATHER:
                begin
                    if (active)
                    begin
                        rb_reg  <= complete ? '0 : rb_new;
                        pos_reg <= complete ? '0 : pos_new;
                    end
                    if (complete && fmt_reg == FMT_DMP)
                        ovf_reg <= (word == OVF_SAMPLE) ? tsat : '0;
                end
                ST_FINISH:
                begin
                    pend_reg <= f_hp;
                    hsum_reg <= f_hs;
                    oidx_reg <= '0;
                    mark_reg <= !f_emit;
                    ocnt_reg <= (f_emit && !f_short) ? 3'd4 : 3'd1;
                    if (last_reg)
                    begin
                        rb_reg  <= '0;
                        pos_reg <= '0;
                        ovf_reg <= '0;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                        oidx_reg <= oidx_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_reg <= in_data.in_byte;
                    last_reg <= in_data.in_last;
                end
            end
            ST_GATHER:
            begin
                got_reg  <= got_now || need_scale;
                useq_reg <= need_scale;
                cyc_reg  <= cyc_now;
            end
            ST_FINISH:
            begin
                if (f_short)
                    obuf_reg[0] <= f_round[10:3];
                else
                    obuf_reg[0] <= 8'd0;
                obuf_reg[1] <= f_d[7:0];
                obuf_reg[2] <= f_d[15:8];
                obuf_reg[3] <= f_d[23:16];
            end
            default: ;
        endcase
    end

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("input taken while results pending");

    a_scale_owned: assert property (@(posedge clk) disable iff (!rst_n)
        scl_busy |-> state_reg == ST_SCALE) else $error("scale unit busy outside scale");

    a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.out_last)
        |=> (!pend_reg && pos_reg == '0 && ovf_reg == '0))
        else $error("stream state not cleared after final transaction");

endmodule
